FILE: rtl/mbrtu_pkg.sv
// Shared types, constants and the byte-wide CRC-16 step for the Modbus RTU master.
// Used by mbrtu_ctrl, mbrtu_out and modbus_rtu_master_transaction.
package mbrtu_pkg;

  // Input item
  typedef struct packed {
    logic [1:0]  req_type;
    logic        op_write;
    logic [15:0] reg_address;
    logic [15:0] count_or_value;
    logic [7:0]  rx_byte;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       last;
    logic [2:0] status;
  } out_item_t;

  // Work handed from the control stage to the output sequencer
  typedef struct packed {
    logic            load;
    logic            is_req;
    logic [2:0]      last_idx;
    logic [5:0][7:0] frame;
    out_item_t       e0;
    out_item_t       e1;
  } burst_t;

  // Input item kinds
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_TX  = 2'd0;
  localparam logic [1:0] KIND_RX  = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  // End status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_CRC_ERR  = 3'd1;
  localparam logic [2:0] ST_EXCEPT   = 3'd2;
  localparam logic [2:0] ST_TIMEOUT  = 3'd3;
  localparam logic [2:0] ST_BUSY     = 3'd4;
  localparam logic [2:0] ST_NOTREADY = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT    = 2'd1;
  localparam logic [1:0] CFG_LINK_READY = 2'd2;

  // Protocol constants
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [7:0]  FC_READ      = 8'h03;
  localparam logic [7:0]  FC_WRITE     = 8'h06;
  localparam logic [7:0]  ADDR_BCAST   = 8'hFF;
  localparam logic [8:0]  LEN_WRITE    = 9'd8;
  localparam logic [8:0]  LEN_EXCEPT   = 9'd5;
  localparam logic [8:0]  LEN_OVERHEAD = 9'd5;

  localparam logic [7:0]  RST_SLAVE_ADDR = 8'd2;
  localparam logic [15:0] RST_TIMEOUT    = 16'd5000;

  // One byte through the reflected CRC-16 (eight shift steps)
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/modbus_rtu_master_transaction.sv
// Modbus RTU master transaction engine: top level.
// Instantiates mbrtu_ctrl and mbrtu_out; depends on mbrtu_pkg.
//
// A user first sets slave_address, timeout_ticks and link_ready through the
// write port (cfg_we, cfg_index, cfg_data), while the block is idle. Each
// input transfer carries a start request, one received byte or a
// one-millisecond tick. A start yields eight request bytes (address, function
// 0x03 or 0x06, register address and count/value big-endian, CRC-16 low byte
// first) with last on the eighth, or a single end item with status busy or
// not ready. Received bytes are framed against the slave address (or FF) and
// the expected function; every accepted frame byte is echoed and the final
// one is followed by an end item with ok, CRC error or exception status.
// Ticks count toward timeout_ticks and end the transaction with a timeout.
// Rate: results leave one per output transfer, from the cycle after the item
// is taken. Items giving zero or one result flow at one per cycle unless
// out_ready stalls; the input holds off until the last result of the previous
// item is transferring, so a start holds it through its request and a
// function byte through its echoes. The CRC is computed a byte per transfer.
module modbus_rtu_master_transaction (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mbrtu_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mbrtu_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  logic              take;
  logic              space;
  mbrtu_pkg::burst_t burst;

  // Accept whenever the output holder is free or draining its final result
  assign in_ready = space;
  assign take     = in_valid && in_ready;

  mbrtu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .in_item   (in_data),
    .burst     (burst)
  );

  mbrtu_out u_out (
    .clk       (clk),
    .rst       (rst),
    .burst     (burst),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/mbrtu_ctrl.sv
// Transaction control: configuration registers, response framing state,
// running CRC and tick counter. Decides the results of each accepted item.
// Depends on mbrtu_pkg.
module mbrtu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                take,
  input  mbrtu_pkg::in_item_t in_item,
  output mbrtu_pkg::burst_t   burst
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_HUNT  = 3'd1,
    PH_FUNC  = 3'd2,
    PH_COUNT = 3'd3,
    PH_BODY  = 3'd4
  } phase_t;

  logic [7:0]  slave_address;
  logic [15:0] timeout_ticks;
  logic        link_ready;

  phase_t      phase, phase_next;
  logic [7:0]  expected_function, expected_function_next;
  logic [7:0]  held_address_byte, held_address_byte_next;
  logic [15:0] held_crc, held_crc_next;
  logic [7:0]  response_function, response_function_next;
  logic [8:0]  frame_length, frame_length_next;
  logic [8:0]  byte_index, byte_index_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  received_crc_low, received_crc_low_next;
  logic [15:0] elapsed_ticks, elapsed_ticks_next;

  logic        busy;
  logic [7:0]  b;
  logic        b_is_addr;
  logic [15:0] b_crc;
  logic [9:0]  idx_plus2;
  logic [9:0]  len_ext;
  logic [15:0] got_crc;

  function automatic mbrtu_pkg::out_item_t end_item(input logic [2:0] st);
    mbrtu_pkg::out_item_t r;
    r.out_kind = mbrtu_pkg::KIND_END;
    r.out_byte = 8'h00;
    r.last     = 1'b1;
    r.status   = st;
    return r;
  endfunction

  function automatic mbrtu_pkg::out_item_t rx_item(input logic [7:0] v);
    mbrtu_pkg::out_item_t r;
    r.out_kind = mbrtu_pkg::KIND_RX;
    r.out_byte = v;
    r.last     = 1'b0;
    r.status   = mbrtu_pkg::ST_OK;
    return r;
  endfunction

  assign busy      = (phase != PH_IDLE);
  assign b         = in_item.rx_byte;
  assign b_is_addr = (b == slave_address) || (b == mbrtu_pkg::ADDR_BCAST);
  assign b_crc     = mbrtu_pkg::crc_byte(running_crc, b);
  assign idx_plus2 = {1'b0, byte_index} + 10'd2;
  assign len_ext   = {1'b0, frame_length};
  assign got_crc   = {b, received_crc_low};

  always_comb begin
    phase_next             = phase;
    expected_function_next = expected_function;
    held_address_byte_next = held_address_byte;
    held_crc_next          = held_crc;
    response_function_next = response_function;
    frame_length_next      = frame_length;
    byte_index_next        = byte_index;
    running_crc_next       = running_crc;
    received_crc_low_next  = received_crc_low;
    elapsed_ticks_next     = elapsed_ticks;
    burst                  = '0;

    if (take) begin
      case (in_item.req_type)
        mbrtu_pkg::REQ_START: begin
          if (!link_ready) begin
            burst.load = 1'b1;
            burst.e0   = end_item(mbrtu_pkg::ST_NOTREADY);
          end else if (busy) begin
            burst.load = 1'b1;
            burst.e0   = end_item(mbrtu_pkg::ST_BUSY);
          end else begin
            burst.load     = 1'b1;
            burst.is_req   = 1'b1;
            burst.last_idx = 3'd7;
            burst.frame[0] = slave_address;
            burst.frame[1] = in_item.op_write ? mbrtu_pkg::FC_WRITE : mbrtu_pkg::FC_READ;
            burst.frame[2] = in_item.reg_address[15:8];
            burst.frame[3] = in_item.reg_address[7:0];
            burst.frame[4] = in_item.count_or_value[15:8];
            burst.frame[5] = in_item.count_or_value[7:0];
            expected_function_next = burst.frame[1];
            phase_next             = PH_HUNT;
            elapsed_ticks_next     = 16'd0;
            byte_index_next        = 9'd0;
            frame_length_next      = 9'd0;
            running_crc_next       = mbrtu_pkg::CRC_INIT;
          end
        end
        mbrtu_pkg::REQ_TICK: begin
          if (busy) begin
            elapsed_ticks_next = elapsed_ticks + 16'd1;
            if (elapsed_ticks_next >= timeout_ticks) begin
              burst.load = 1'b1;
              burst.e0   = end_item(mbrtu_pkg::ST_TIMEOUT);
              phase_next = PH_IDLE;
            end
          end
        end
        mbrtu_pkg::REQ_BYTE: begin
          if (busy) begin
            case (phase)
              PH_HUNT: begin
                if (b_is_addr) begin
                  held_address_byte_next = b;
                  held_crc_next          = mbrtu_pkg::crc_byte(mbrtu_pkg::CRC_INIT, b);
                  phase_next             = PH_FUNC;
                end
              end
              PH_FUNC: begin
                if ((b == expected_function && b == mbrtu_pkg::FC_READ) ||
                    (b == expected_function && b == mbrtu_pkg::FC_WRITE) || b[7]) begin
                  if (b == expected_function && b == mbrtu_pkg::FC_READ) begin
                    phase_next = PH_COUNT;
                  end else if (b == expected_function && b == mbrtu_pkg::FC_WRITE) begin
                    frame_length_next = mbrtu_pkg::LEN_WRITE;
                    phase_next        = PH_BODY;
                  end else begin
                    frame_length_next = mbrtu_pkg::LEN_EXCEPT;
                    phase_next        = PH_BODY;
                  end
                  response_function_next = b;
                  running_crc_next       = mbrtu_pkg::crc_byte(held_crc, b);
                  byte_index_next        = 9'd2;
                  burst.load             = 1'b1;
                  burst.last_idx         = 3'd1;
                  burst.e0               = rx_item(held_address_byte);
                  burst.e1               = rx_item(b);
                end else if (b_is_addr) begin
                  held_address_byte_next = b;
                  held_crc_next          = mbrtu_pkg::crc_byte(mbrtu_pkg::CRC_INIT, b);
                end else begin
                  phase_next = PH_HUNT;
                end
              end
              PH_COUNT: begin
                frame_length_next = {1'b0, b} + mbrtu_pkg::LEN_OVERHEAD;
                running_crc_next  = b_crc;
                byte_index_next   = 9'd3;
                phase_next        = PH_BODY;
                burst.load        = 1'b1;
                burst.e0          = rx_item(b);
              end
              PH_BODY: begin
                burst.load      = 1'b1;
                burst.e0        = rx_item(b);
                byte_index_next = byte_index + 9'd1;
                if (idx_plus2 < len_ext) begin
                  running_crc_next = b_crc;
                end else if (idx_plus2 == len_ext) begin
                  received_crc_low_next = b;
                end else begin
                  // closing CRC byte: echo it, then report
                  burst.last_idx = 3'd1;
                  if (got_crc != running_crc) begin
                    burst.e1 = end_item(mbrtu_pkg::ST_CRC_ERR);
                  end else if (response_function[7]) begin
                    burst.e1 = end_item(mbrtu_pkg::ST_EXCEPT);
                  end else begin
                    burst.e1 = end_item(mbrtu_pkg::ST_OK);
                  end
                  phase_next = PH_IDLE;
                end
              end
              default: phase_next = PH_HUNT;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address     <= mbrtu_pkg::RST_SLAVE_ADDR;
      timeout_ticks     <= mbrtu_pkg::RST_TIMEOUT;
      link_ready        <= 1'b0;
      phase             <= PH_IDLE;
      expected_function <= 8'h00;
      held_address_byte <= 8'h00;
      held_crc          <= mbrtu_pkg::CRC_INIT;
      response_function <= 8'h00;
      frame_length      <= 9'd0;
      byte_index        <= 9'd0;
      running_crc       <= mbrtu_pkg::CRC_INIT;
      received_crc_low  <= 8'h00;
      elapsed_ticks     <= 16'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mbrtu_pkg::CFG_SLAVE_ADDR: slave_address <= cfg_data[7:0];
          mbrtu_pkg::CFG_TIMEOUT:    timeout_ticks <= cfg_data;
          mbrtu_pkg::CFG_LINK_READY: link_ready    <= cfg_data[0];
          default: ;
        endcase
      end
      phase             <= phase_next;
      expected_function <= expected_function_next;
      held_address_byte <= held_address_byte_next;
      held_crc          <= held_crc_next;
      response_function <= response_function_next;
      frame_length      <= frame_length_next;
      byte_index        <= byte_index_next;
      running_crc       <= running_crc_next;
      received_crc_low  <= received_crc_low_next;
      elapsed_ticks     <= elapsed_ticks_next;
    end
  end

  // In the body the index never reaches the frame length
  a_body_index: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> byte_index < frame_length)
    else $error("body index past frame length");

  // A start refused for being busy leaves the framing phase alone
  a_busy_start_hold: assert property (@(posedge clk) disable iff (rst)
    (take && in_item.req_type == mbrtu_pkg::REQ_START && link_ready && busy)
      |=> phase == $past(phase))
    else $error("busy start disturbed the phase");

endmodule

FILE: rtl/mbrtu_out.sv
// Output sequencer: holds the results of one item and hands them out one per
// transfer; computes the request CRC byte by byte as the frame goes out.
// Depends on mbrtu_pkg.
module mbrtu_out (
  input  logic                 clk,
  input  logic                 rst,
  input  mbrtu_pkg::burst_t    burst,
  output logic                 space,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mbrtu_pkg::out_item_t out_data
);

  logic                 active;
  logic [2:0]           idx;
  logic [2:0]           last_idx;
  logic                 is_req;
  logic [5:0][7:0]      frame;
  logic [15:0]          crc;
  mbrtu_pkg::out_item_t e0;
  mbrtu_pkg::out_item_t e1;

  logic                 xfer;
  logic                 finishing;
  logic [7:0]           req_byte;

  assign out_valid = active;
  assign xfer      = active && out_ready;
  assign finishing = xfer && (idx == last_idx);
  assign space     = !active || finishing;

  always_comb begin
    if (idx < 3'd6) begin
      req_byte = frame[idx];
    end else if (idx == 3'd6) begin
      req_byte = crc[7:0];
    end else begin
      req_byte = crc[15:8];
    end
  end

  always_comb begin
    if (is_req) begin
      out_data.out_kind = mbrtu_pkg::KIND_TX;
      out_data.out_byte = req_byte;
      out_data.last     = (idx == 3'd7);
      out_data.status   = mbrtu_pkg::ST_OK;
    end else if (idx == 3'd0) begin
      out_data = e0;
    end else begin
      out_data = e1;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= 3'd0;
    end else if (burst.load) begin
      active <= 1'b1;
      idx    <= 3'd0;
    end else if (xfer) begin
      if (idx == last_idx) begin
        active <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (burst.load) begin
      is_req   <= burst.is_req;
      last_idx <= burst.last_idx;
      frame    <= burst.frame;
      e0       <= burst.e0;
      e1       <= burst.e1;
      crc      <= mbrtu_pkg::CRC_INIT;
    end else if (xfer && is_req && idx < 3'd6) begin
      crc <= mbrtu_pkg::crc_byte(crc, req_byte);
    end
  end

  // New results only land on an empty holder or one draining its final result
  a_load_space: assert property (@(posedge clk) disable iff (rst)
    burst.load |-> (!active || finishing))
    else $error("results loaded over pending results");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    active |-> idx <= last_idx)
    else $error("result index past last");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for modbus_rtu_master_transaction: directed and random Modbus traffic.
// Each input transfer goes through a predictor, and every output transfer is scored against it.
// Depends on mbrtu_pkg and the RTL top level only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // The package names three input kinds; the fourth encoding must be ignored.
  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam int         QUIET_LIMIT  = 2000;  // cycles with no transfer before giving up
  localparam int         HOLD_CYCLES  = 300;   // long receiver hold-off for the pressure test
  localparam int         RANDOM_ITEMS = 20;

  typedef enum logic [2:0] {PH_IDLE, PH_HUNT, PH_FUNC, PH_COUNT, PH_BODY} rx_phase_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  mbrtu_pkg::in_item_t  in_data;
  logic                 out_valid;
  logic                 out_ready;
  mbrtu_pkg::out_item_t out_data;
  logic                 cfg_we;
  logic [1:0]           cfg_index;
  logic [15:0]          cfg_data;

  modbus_rtu_master_transaction dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register mirror, kept in step with every write on the config port.
  logic [7:0]  cfg_slave   = mbrtu_pkg::RST_SLAVE_ADDR;
  logic [15:0] cfg_timeout = mbrtu_pkg::RST_TIMEOUT;
  logic        cfg_link    = 1'b0;

  // Transaction state of the predicted master.
  logic        m_busy     = 1'b0;
  rx_phase_t   m_phase    = PH_IDLE;
  logic [7:0]  m_expect_fc = 8'h00;
  logic [7:0]  m_held_addr = 8'h00;
  logic [7:0]  m_resp_fc  = 8'h00;
  int          m_len      = 0;
  int          m_idx      = 0;
  logic [15:0] m_crc      = mbrtu_pkg::CRC_INIT;
  logic [7:0]  m_crc_lo   = 8'h00;
  logic [15:0] m_ticks    = 16'h0000;

  // Master outputs predicted but not yet seen on the output port, oldest first.
  mbrtu_pkg::out_item_t due_items[$];
  logic [7:0]           reply_bytes[$];

  int  errors          = 0;
  int  items_fed       = 0;
  int  results_checked = 0;
  int  ends_by_status[8];
  bit  gaps_on         = 1'b1;
  bit  stalls_on       = 1'b1;
  bit  mix_ticks       = 1'b0;
  bit  hold_off_req    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Reflected CRC-16, one byte, LSB first.
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ mbrtu_pkg::CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic mbrtu_pkg::out_item_t result_of(input logic [1:0] kind,
                                                     input logic [7:0] b,
                                                     input logic lst, input logic [2:0] st);
    mbrtu_pkg::out_item_t r;
    r.out_kind = kind;
    r.out_byte = b;
    r.last     = lst;
    r.status   = st;
    return r;
  endfunction

  function automatic bit addr_match(input logic [7:0] b);
    return b == cfg_slave || b == mbrtu_pkg::ADDR_BCAST;
  endfunction

  // Append one predicted result at the tail of the due list.
  task automatic queue_result(input mbrtu_pkg::out_item_t r);
    due_items = {due_items, r};
  endtask

  task automatic close_txn(input logic [2:0] st);
    queue_result(result_of(mbrtu_pkg::KIND_END, 8'h00, 1'b1, st));
    m_busy  = 1'b0;
    m_phase = PH_IDLE;
  endtask

  // Advance the master by one accepted input item and queue what it must emit.
  task automatic master_step(input mbrtu_pkg::in_item_t it);
    logic [7:0]  f[8];
    logic [15:0] c;
    logic [7:0]  b;
    logic [2:0]  st;
    b = it.rx_byte;
    case (it.req_type)
      mbrtu_pkg::REQ_START: begin
        // Not-ready wins over busy; a busy start leaves the open transaction alone.
        if (!cfg_link) begin
          queue_result(result_of(mbrtu_pkg::KIND_END, 8'h00, 1'b1, mbrtu_pkg::ST_NOTREADY));
        end else if (m_busy) begin
          queue_result(result_of(mbrtu_pkg::KIND_END, 8'h00, 1'b1, mbrtu_pkg::ST_BUSY));
        end else begin
          f[0] = cfg_slave;
          f[1] = it.op_write ? mbrtu_pkg::FC_WRITE : mbrtu_pkg::FC_READ;
          f[2] = it.reg_address[15:8];
          f[3] = it.reg_address[7:0];
          f[4] = it.count_or_value[15:8];
          f[5] = it.count_or_value[7:0];
          c = mbrtu_pkg::CRC_INIT;
          for (int i = 0; i < 6; i++) c = crc16_step(c, f[i]);
          f[6] = c[7:0];
          f[7] = c[15:8];
          for (int i = 0; i < 8; i++)
            queue_result(result_of(mbrtu_pkg::KIND_TX, f[i], i == 7, mbrtu_pkg::ST_OK));
          m_busy      = 1'b1;
          m_expect_fc = f[1];
          m_phase     = PH_HUNT;
          m_ticks     = 16'h0000;
          m_idx       = 0;
          m_len       = 0;
          m_crc       = mbrtu_pkg::CRC_INIT;
        end
      end
      mbrtu_pkg::REQ_TICK: begin
        if (m_busy) begin
          m_ticks = m_ticks + 16'd1;
          if (m_ticks >= cfg_timeout) close_txn(mbrtu_pkg::ST_TIMEOUT);
        end
      end
      mbrtu_pkg::REQ_BYTE: begin
        if (m_busy) begin
          case (m_phase)
            PH_HUNT: begin
              if (addr_match(b)) begin
                m_held_addr = b;
                m_phase     = PH_FUNC;
              end
            end
            PH_FUNC: begin
              if (b == m_expect_fc && b == mbrtu_pkg::FC_READ ||
                  b == m_expect_fc && b == mbrtu_pkg::FC_WRITE || b[7]) begin
                if (b == m_expect_fc && b == mbrtu_pkg::FC_READ) begin
                  m_phase = PH_COUNT;
                end else begin
                  m_len   = (b == m_expect_fc && b == mbrtu_pkg::FC_WRITE) ?
                            int'(mbrtu_pkg::LEN_WRITE) : int'(mbrtu_pkg::LEN_EXCEPT);
                  m_phase = PH_BODY;
                end
                m_resp_fc = b;
                m_crc     = crc16_step(crc16_step(mbrtu_pkg::CRC_INIT, m_held_addr), b);
                m_idx     = 2;
                queue_result(result_of(mbrtu_pkg::KIND_RX, m_held_addr, 1'b0, mbrtu_pkg::ST_OK));
                queue_result(result_of(mbrtu_pkg::KIND_RX, b, 1'b0, mbrtu_pkg::ST_OK));
              end else if (addr_match(b)) begin
                // A rejected function byte that looks like an address restarts the frame.
                m_held_addr = b;
              end else begin
                m_phase = PH_HUNT;
              end
            end
            PH_COUNT: begin
              m_len   = int'(b) + int'(mbrtu_pkg::LEN_OVERHEAD);
              m_crc   = crc16_step(m_crc, b);
              m_idx   = 3;
              m_phase = PH_BODY;
              queue_result(result_of(mbrtu_pkg::KIND_RX, b, 1'b0, mbrtu_pkg::ST_OK));
            end
            PH_BODY: begin
              queue_result(result_of(mbrtu_pkg::KIND_RX, b, 1'b0, mbrtu_pkg::ST_OK));
              if (m_idx + 2 < m_len) begin
                m_crc = crc16_step(m_crc, b);
              end else if (m_idx + 2 == m_len) begin
                m_crc_lo = b;
              end else begin
                if ({b, m_crc_lo} != m_crc) st = mbrtu_pkg::ST_CRC_ERR;
                else if (m_resp_fc[7])      st = mbrtu_pkg::ST_EXCEPT;
                else                        st = mbrtu_pkg::ST_OK;
                close_txn(st);
              end
              m_idx = m_idx + 1;
            end
            default: m_phase = PH_HUNT;
          endcase
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus side
  // ---------------------------------------------------------------------------

  // Fields that the item kind does not use still get random values.
  function automatic mbrtu_pkg::in_item_t make_item(input logic [1:0] kind);
    mbrtu_pkg::in_item_t it;
    it.req_type       = kind;
    it.op_write       = 1'($urandom_range(0, 1));
    it.reg_address    = 16'($urandom_range(0, 65535));
    it.count_or_value = 16'($urandom_range(0, 65535));
    it.rx_byte        = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // Offer one item, hold it until the transfer, then predict its outputs.
  task automatic send_item(input mbrtu_pkg::in_item_t it);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_fed++;
    master_step(it);
  endtask

  task automatic send_start(input logic op, input logic [15:0] a, input logic [15:0] v);
    mbrtu_pkg::in_item_t it;
    it = make_item(mbrtu_pkg::REQ_START);
    it.op_write       = op;
    it.reg_address    = a;
    it.count_or_value = v;
    send_item(it);
  endtask

  task automatic send_byte(input logic [7:0] b);
    mbrtu_pkg::in_item_t it;
    it = make_item(mbrtu_pkg::REQ_BYTE);
    it.rx_byte = b;
    send_item(it);
  endtask

  task automatic send_tick();
    send_item(make_item(mbrtu_pkg::REQ_TICK));
  endtask

  // Send reply_bytes as a slave frame; append its CRC unless cut, flip one bit if corrupt.
  task automatic send_reply(input bit corrupt, input bit cut);
    logic [15:0] c;
    c = mbrtu_pkg::CRC_INIT;
    for (int i = 0; i < reply_bytes.size(); i++) begin
      if (mix_ticks && $urandom_range(0, 9) == 0) send_tick();
      send_byte(reply_bytes[i]);
      c = crc16_step(c, reply_bytes[i]);
    end
    if (!cut) begin
      if (corrupt) c = c ^ (16'h0001 << $urandom_range(0, 15));
      send_byte(c[7:0]);
      send_byte(c[15:8]);
    end
  endtask

  // Drop valid, drain every due output, then leave room for zero-output items in flight.
  task automatic settle();
    in_valid <= 1'b0;
    while (due_items.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] wdata);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= wdata;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mbrtu_pkg::CFG_SLAVE_ADDR: cfg_slave   = wdata[7:0];
      mbrtu_pkg::CFG_TIMEOUT:    cfg_timeout = wdata;
      mbrtu_pkg::CFG_LINK_READY: cfg_link    = wdata[0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checking
  // ---------------------------------------------------------------------------

  // Stall the output in random bursts; on request hold it off for one long stretch.
  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        out_ready <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t ns, result %0d: %s got %0d, expected %0d",
             $time, results_checked, what, got, want);
    errors++;
  endtask

  // Score every output transfer against the oldest due item.
  always @(posedge clk) begin
    mbrtu_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      results_checked++;
      if (out_data.out_kind == mbrtu_pkg::KIND_END) ends_by_status[out_data.status]++;
      if (due_items.size() == 0) begin
        report_mismatch("output with nothing due, out_kind", int'(out_data.out_kind), -1);
      end else begin
        want = due_items.pop_front();
        if (out_data.out_kind !== want.out_kind)
          report_mismatch("out_kind", int'(out_data.out_kind), int'(want.out_kind));
        if (out_data.out_byte !== want.out_byte)
          report_mismatch("out_byte", int'(out_data.out_byte), int'(want.out_byte));
        if (out_data.last !== want.last)
          report_mismatch("last", int'(out_data.last), int'(want.last));
        if (out_data.status !== want.status)
          report_mismatch("status", int'(out_data.status), int'(want.status));
      end
    end
  end

  // End the run if nothing moves on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Watchdog: no transfer for %0d cycles, %0d outputs still due",
             QUIET_LIMIT, due_items.size());
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Link is down after reset: a start ends at once, everything else is ignored.
  task automatic test_idle_and_not_ready();
    send_start(1'b0, 16'h0001, 16'h0001);
    send_byte(mbrtu_pkg::RST_SLAVE_ADDR);
    send_tick();
    send_item(make_item(REQ_UNUSED));
  endtask

  // Read with slave address 0: stray byte while hunting, a repeated address in the
  // function slot, then a reply with a single data byte.
  task automatic test_read_frame();
    write_reg(mbrtu_pkg::CFG_LINK_READY, 16'h0001);
    write_reg(mbrtu_pkg::CFG_SLAVE_ADDR, 16'h0000);
    send_start(1'b0, 16'hFFFF, 16'hFFFF);
    send_byte(8'h55);
    send_byte(8'h00);
    reply_bytes = {8'h00, mbrtu_pkg::FC_READ, 8'h01, 8'hA5};
    send_reply(1'b0, 1'b0);
  endtask

  // Slave address FF: an exception reply, then a write whose first function byte is
  // rejected and whose echo carries a bad CRC.
  task automatic test_write_and_errors();
    write_reg(mbrtu_pkg::CFG_SLAVE_ADDR, 16'h00FF);
    send_start(1'b1, 16'h0000, 16'h0000);
    reply_bytes = {8'hFF, 8'h86, 8'h02};
    send_reply(1'b0, 1'b0);
    send_start(1'b1, 16'h1234, 16'hBEEF);
    send_byte(8'hFF);
    send_byte(8'h10);
    reply_bytes = {8'hFF, mbrtu_pkg::FC_WRITE, 8'h12, 8'h34, 8'hBE, 8'hEF};
    send_reply(1'b1, 1'b0);
  endtask

  // Start while busy, then drop the link with the transaction open: starts report
  // not ready, but the open transaction still completes.
  task automatic test_busy_and_link_drop();
    write_reg(mbrtu_pkg::CFG_SLAVE_ADDR, 16'h0011);
    send_start(1'b0, 16'h0010, 16'h0002);
    send_start(1'b1, 16'h0020, 16'h5555);
    write_reg(mbrtu_pkg::CFG_LINK_READY, 16'h0000);
    send_start(1'b0, 16'h0030, 16'h0001);
    send_item(make_item(REQ_UNUSED));
    reply_bytes = {8'h11, mbrtu_pkg::FC_READ, 8'h04, 8'hDE, 8'hAD, 8'h00, 8'hFF};
    send_reply(1'b0, 1'b0);
    write_reg(mbrtu_pkg::CFG_LINK_READY, 16'h0001);
  endtask

  // Timeout at the lowest limit, mid-frame, and a long limit that never fires.
  task automatic test_timeout();
    write_reg(mbrtu_pkg::CFG_TIMEOUT, 16'd1);
    send_start(1'b0, 16'h0100, 16'h0001);
    send_tick();
    write_reg(mbrtu_pkg::CFG_TIMEOUT, 16'd3);
    send_start(1'b0, 16'h0200, 16'h0001);
    send_tick();
    send_byte(cfg_slave);
    send_tick();
    send_tick();
    send_byte(mbrtu_pkg::FC_READ);
    write_reg(mbrtu_pkg::CFG_TIMEOUT, 16'hFFFF);
    send_start(1'b1, 16'h8001, 16'h7FFE);
    repeat (5) send_tick();
    reply_bytes = {cfg_slave, mbrtu_pkg::FC_WRITE, 8'h80, 8'h01, 8'h7F, 8'hFE};
    send_reply(1'b0, 1'b0);
  endtask

  // Largest byte count: the frame length must not wrap, so a few body bytes are
  // echoed without an early end, and the cut frame closes on a timeout.
  task automatic test_max_byte_count();
    write_reg(mbrtu_pkg::CFG_TIMEOUT, 16'd3);
    send_start(1'b0, 16'h0000, 16'h007F);
    reply_bytes = {cfg_slave, mbrtu_pkg::FC_READ, 8'hFF};
    repeat (6) reply_bytes = {reply_bytes, 8'($urandom_range(0, 255))};
    send_reply(1'b0, 1'b1);
    while (m_busy) send_tick();
  endtask

  // Hold the receiver off while the sender keeps offering: the request burst fills the
  // output side and the input must stall until it drains.
  task automatic test_backpressure();
    gaps_on      = 1'b0;
    hold_off_req = 1'b1;
    send_start(1'b0, 16'h4000, 16'h0002);
    repeat (3) send_start(1'b1, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    send_tick();
    reply_bytes = {mbrtu_pkg::ADDR_BCAST, mbrtu_pkg::FC_READ, 8'h02, 8'h3C, 8'hC3};
    send_reply(1'b0, 1'b0);
    gaps_on = 1'b1;
  endtask

  // Complete transactions with random content, mixed with stray bytes,
  // rejected functions, exceptions, bad CRCs and cut frames that end on a timeout.
  task automatic test_random_traffic();
    int         goal;
    int         kind;
    int         n;
    bit         op;
    logic [7:0] addr;
    goal = items_fed + RANDOM_ITEMS;
    write_reg(mbrtu_pkg::CFG_TIMEOUT, 16'($urandom_range(4, 8)));
    mix_ticks = 1'b1;
    while (items_fed < goal) begin
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0)
        write_reg(mbrtu_pkg::CFG_SLAVE_ADDR, 16'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) == 0)
        write_reg(mbrtu_pkg::CFG_TIMEOUT, 16'($urandom_range(1, 8)));
      if ($urandom_range(0, 11) == 0) begin
        write_reg(mbrtu_pkg::CFG_LINK_READY, 16'h0000);
        send_start(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)), 16'h0001);
        write_reg(mbrtu_pkg::CFG_LINK_READY, 16'h0001);
      end
      op = 1'($urandom_range(0, 1));
      send_start(op, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      if ($urandom_range(0, 7) == 0)
        send_start(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)), 16'h0003);
      if ($urandom_range(0, 15) == 0) send_item(make_item(REQ_UNUSED));

      kind = $urandom_range(0, 9);
      addr = $urandom_range(0, 1) ? cfg_slave : mbrtu_pkg::ADDR_BCAST;
      if (kind >= 8) begin
        // Line noise only
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 3) == 0) send_byte(8'($urandom_range(0, 255)));
        if (kind == 4) begin
          // Address followed by a function byte without bit 7
          send_byte(addr);
          send_byte(8'($urandom_range(0, 127)));
        end
        reply_bytes = {addr};
        if (kind == 5) begin
          reply_bytes = {reply_bytes, 8'h80 | 8'($urandom_range(0, 127)),
                         8'($urandom_range(0, 255))};
        end else if (op) begin
          reply_bytes = {reply_bytes, mbrtu_pkg::FC_WRITE};
          repeat (4) reply_bytes = {reply_bytes, 8'($urandom_range(0, 255))};
        end else begin
          n = $urandom_range(0, 6);
          reply_bytes = {reply_bytes, mbrtu_pkg::FC_READ, 8'(n)};
          repeat (n) reply_bytes = {reply_bytes, 8'($urandom_range(0, 255))};
        end
        send_reply(kind == 6, kind == 7);
      end
      // Close whatever is still open through the timeout.
      while (m_busy) send_tick();
    end
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_tail_no_idle();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    mix_ticks = 1'b0;
    send_start(1'b0, 16'h0A0B, 16'h0001);
    reply_bytes = {cfg_slave, mbrtu_pkg::FC_READ, 8'h01, 8'h80};
    send_reply(1'b0, 1'b0);
    send_start(1'b1, 16'hC0DE, 16'h0F0F);
    reply_bytes = {mbrtu_pkg::ADDR_BCAST, mbrtu_pkg::FC_WRITE, 8'hC0, 8'hDE, 8'h0F, 8'h0F};
    send_reply(1'b0, 1'b0);
    while (m_busy) send_tick();
  endtask

  initial begin
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rst       <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_and_not_ready();
    test_read_frame();
    test_write_and_errors();
    test_busy_and_link_drop();
    test_timeout();
    test_max_byte_count();
    test_backpressure();
    test_random_traffic();
    test_tail_no_idle();

    // Drain and watch for stray outputs before the verdict.
    in_valid <= 1'b0;
    while (due_items.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d input items and %0d checked outputs.",
             items_fed, results_checked);
    $display("Ends by status: ok %0d, crc %0d, exception %0d, timeout %0d, busy %0d, %s %0d",
             ends_by_status[mbrtu_pkg::ST_OK], ends_by_status[mbrtu_pkg::ST_CRC_ERR],
             ends_by_status[mbrtu_pkg::ST_EXCEPT], ends_by_status[mbrtu_pkg::ST_TIMEOUT],
             ends_by_status[mbrtu_pkg::ST_BUSY], "not ready",
             ends_by_status[mbrtu_pkg::ST_NOTREADY]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
